@@ rtl/core/piecewise_linear_membership_assert.svh @@
`ifndef PIECEWISE_LINEAR_MEMBERSHIP_ASSERT_SVH
`define PIECEWISE_LINEAR_MEMBERSHIP_ASSERT_SVH

// same-edge implication, off while reset is held
`define PLM_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// consequent a fixed number of edges later
`define PLM_ASSERT_AFTER(lbl, ant, n, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> ##(n) (cons)) \
        else $error(msg);

`endif

@@ rtl/core/plm_pkg.sv @@
package plm_pkg;

    localparam int POINT_REGS = 4;
    localparam int IDX_W      = 3;
    localparam int DIV_BITS   = 16;

    localparam logic [IDX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_POINT0      = 3'd1;

    localparam logic [16:0] ONE_Q15 = 17'd32768;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
        logic [31:0]      data;
    } t_cfg_wr;

    // y0 + (dy * dx) / den
    typedef struct packed {
        logic [15:0]        y0;
        logic signed [16:0] dy;
        logic [15:0]        dx;
        logic [15:0]        den;
    } t_item;

endpackage

@@ rtl/core/plm_front.sv @@
module plm_front #(
    parameter int N_PTS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic signed [15:0]  i_crisp_value,
    input  plm_pkg::t_cfg_wr    i_cfg,
    output logic                o_valid,
    output plm_pkg::t_item      o_item
);
    import plm_pkg::*;

    localparam logic [IDX_W-1:0] NP = IDX_W'(N_PTS);

    logic [IDX_W-1:0] r_count;
    logic [31:0]      r_points [N_PTS];
    logic             r_valid;
    t_item            r_item;

    logic [IDX_W-1:0] n_eff;
    logic             found;
    logic [16:0]      dx_full;
    logic [16:0]      den_full;
    t_item            n_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < N_PTS; i++) begin
                r_points[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_POINT_COUNT) begin
                r_count <= i_cfg.data[IDX_W-1:0];
            end
            for (int i = 0; i < N_PTS; i++) begin
                if (i_cfg.index == REG_POINT0 + IDX_W'(i)) begin
                    r_points[i] <= i_cfg.data;
                end
            end
        end
    end

    always_comb begin
        n_eff       = (r_count > NP) ? NP : r_count;
        found       = 1'b0;
        dx_full     = '0;
        den_full    = '0;
        n_item.y0   = '0;
        n_item.dy   = '0;
        n_item.dx   = '0;
        n_item.den  = 16'd1;
        if (n_eff == '0) begin
            n_item.y0 = '0;
        end else if (i_crisp_value < $signed(r_points[0][31:16])) begin
            n_item.y0 = r_points[0][15:0];
        end else begin
            for (int i = 1; i < N_PTS; i++) begin
                if (!found && (IDX_W'(i) < n_eff)
                        && (i_crisp_value < $signed(r_points[i][31:16]))) begin
                    found     = 1'b1;
                    n_item.y0 = r_points[i-1][15:0];
                    n_item.dy = $signed({1'b0, r_points[i][15:0]})
                              - $signed({1'b0, r_points[i-1][15:0]});
                    dx_full   = {i_crisp_value[15], i_crisp_value}
                              - {r_points[i-1][31], r_points[i-1][31:16]};
                    den_full  = {r_points[i][31], r_points[i][31:16]}
                              - {r_points[i-1][31], r_points[i-1][31:16]};
                    n_item.dx  = dx_full[15:0];
                    n_item.den = den_full[15:0];
                end
            end
            if (!found) begin
                for (int i = 0; i < N_PTS; i++) begin
                    if (IDX_W'(i) == n_eff - 1'b1) begin
                        n_item.y0 = r_points[i][15:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/core/plm_queue.sv @@
module plm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  plm_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_valid,
    output plm_pkg::t_item  o_item,
    output logic            o_full
);
    import plm_pkg::*;

    localparam int Q_DEPTH = 2;

    t_item       r_mem [Q_DEPTH];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    logic        do_push;
    logic        do_pop;

    assign o_full  = (r_count == 2'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ rtl/core/plm_back.sv @@
module plm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  plm_pkg::t_item  i_item,
    output logic            o_strobe,
    output logic [15:0]     o_membership
);
    import plm_pkg::*;

    // multiply stage
    logic               r_m_valid;
    logic signed [33:0] r_m_prod;
    logic [15:0]        r_m_den;
    logic [15:0]        r_m_y0;

    logic signed [16:0] m_dy;
    logic signed [16:0] m_dx;
    logic signed [33:0] abs_full;

    // divider stages; index 0 is the magnitude stage
    logic        r_vd   [0:DIV_BITS];
    logic [15:0] r_quo  [0:DIV_BITS];
    logic [15:0] r_y0   [0:DIV_BITS];
    logic        r_neg  [0:DIV_BITS];
    logic [15:0] r_rem  [0:DIV_BITS-1];
    logic [15:0] r_low  [0:DIV_BITS-1];
    logic [15:0] r_den  [0:DIV_BITS-1];

    logic               r_o_strobe;
    logic [15:0]        r_o_memb;

    logic signed [17:0] q_s;
    logic signed [17:0] sum;
    logic [15:0]        n_memb;

    assign m_dy = i_item.dy;
    assign m_dx = $signed({1'b0, i_item.dx});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_m_prod <= m_dy * m_dx;
            r_m_den  <= i_item.den;
            r_m_y0   <= i_item.y0;
        end
    end

    assign abs_full = r_m_prod[33] ? -r_m_prod : r_m_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else begin
            r_vd[0] <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_m_valid) begin
            r_rem[0] <= abs_full[31:16];
            r_low[0] <= abs_full[15:0];
            r_quo[0] <= '0;
            r_den[0] <= r_m_den;
            r_y0[0]  <= r_m_y0;
            r_neg[0] <= r_m_prod[33];
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        logic [16:0] trial;
        logic        ge;

        assign trial = {r_rem[k], r_low[k][15]};
        assign ge    = (trial >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k+1] <= 1'b0;
            end else begin
                r_vd[k+1] <= r_vd[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (r_vd[k]) begin
                r_quo[k+1] <= {r_quo[k][14:0], ge};
                r_y0[k+1]  <= r_y0[k];
                r_neg[k+1] <= r_neg[k];
            end
        end

        if (k < DIV_BITS - 1) begin : g_carry
            logic [16:0] diff;

            assign diff = trial - {1'b0, r_den[k]};

            always_ff @(posedge i_clk) begin
                if (r_vd[k]) begin
                    r_rem[k+1] <= ge ? diff[15:0] : trial[15:0];
                    r_low[k+1] <= {r_low[k][14:0], 1'b0};
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    always_comb begin
        q_s = $signed({2'b00, r_quo[DIV_BITS]});
        sum = $signed({2'b00, r_y0[DIV_BITS]}) + (r_neg[DIV_BITS] ? -q_s : q_s);
        priority if (sum[17]) begin
            n_memb = '0;
        end else if (sum[16:0] > ONE_Q15) begin
            n_memb = ONE_Q15[15:0];
        end else begin
            n_memb = sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= r_vd[DIV_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vd[DIV_BITS]) begin
            r_o_memb <= n_memb;
        end
    end

    assign o_strobe     = r_o_strobe;
    assign o_membership = r_o_memb;

endmodule

@@ rtl/core/piecewise_linear_membership.sv @@
// Piecewise-linear membership of one fuzzy set, Q1.15 result (32768 = 1.0).
// Input: a word is taken at a rising edge with start high and busy low;
//   i_crisp_value is signed 16 bit. One word may be taken every cycle.
// Config: i_cfg_valid/o_cfg_ready write channel, i_cfg_index selects
//   0 = point count, 1..4 = points (x in 31:16 signed, y in 15:0).
//   Points above MAX_POINTS are not stored. Write only while idle.
// Output: o_membership is shown with o_strobe high for exactly one cycle.
//   o_strobe is set through the front register, the queue, the multiply,
//   magnitude, divide and clamp stages; results leave in input order.
// Throughput: one word per cycle; the front classifier, a two-word queue
//   and the back pipeline (one multiply stage, a magnitude stage, 16
//   restoring divide stages, one clamp stage) each take one word a cycle.
// Reset (i_rst_n low, synchronous) clears the point registers, counters and
//   valid flags and empties the pipeline; busy and o_cfg_ready follow reset.
// The receiver cannot stall: every strobe is a delivered result.
module piecewise_linear_membership #(
    parameter int MAX_POINTS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [15:0]          i_crisp_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [plm_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    output logic                        o_strobe,
    output logic [15:0]                 o_membership
);
    import plm_pkg::*;

    localparam int N_PTS = (MAX_POINTS < POINT_REGS) ? MAX_POINTS : POINT_REGS;

    logic    accept;
    t_cfg_wr cfg_wr;
    logic    f_valid;
    t_item   f_item;
    logic    q_valid;
    t_item   q_item;
    logic    q_full;

    assign busy        = !i_rst_n || q_full;
    assign o_cfg_ready = i_rst_n;
    assign accept      = start && !busy;

    assign cfg_wr.valid = i_cfg_valid && o_cfg_ready;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    plm_front #(
        .N_PTS (N_PTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_crisp_value (i_crisp_value),
        .i_cfg         (cfg_wr),
        .o_valid       (f_valid),
        .o_item        (f_item)
    );

    plm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .i_pop   (q_valid),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_full  (q_full)
    );

    plm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_strobe     (o_strobe),
        .o_membership (o_membership)
    );

endmodule

@@ rtl/core/plm_checker.sv @@
`include "piecewise_linear_membership_assert.svh"

module plm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [15:0] o_membership
);

    localparam int LAT_EDGES = 21;

    `PLM_ASSERT_IMP(a_range, o_strobe, o_membership <= 16'h8000, "membership above 1.0")
    `PLM_ASSERT_IMP(a_origin, o_strobe, $past(start && !busy, LAT_EDGES), "result without word")
    `PLM_ASSERT_AFTER(a_latency, start && !busy, LAT_EDGES, o_strobe, "word lost")

endmodule

bind piecewise_linear_membership plm_checker u_plm_checker (.*);
